// File: rtl/core/frx_pkg.sv
// Shared types and constants for the preamble-synchronized frame receiver.
// No dependencies; imported by every module under rtl/core.
package frx_pkg;

  localparam int unsigned BUF_BYTES = 128;
  localparam int unsigned SYNC_LEN  = 4;
  localparam logic [7:0]  SYNC_BYTE = 8'h02;
  localparam logic [2:0]  CRC_BYTES = 3'd4;

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_PREAMBLE = 3'd1,
    KIND_COMMAND  = 3'd2,
    KIND_ID       = 3'd3,
    KIND_LENGTH   = 3'd4,
    KIND_DATA     = 3'd5,
    KIND_CRC      = 3'd6
  } frx_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INVALID  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } frx_err_t;

  // Input register contents handed to the decode stage.
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } frx_beat_t;

  // One labeled result beat.
  typedef struct packed {
    logic [7:0] byte_value;
    logic [7:0] frame_position;
    frx_kind_t  byte_kind;
    logic       frame_done;
    frx_err_t   error_code;
  } frx_result_t;

endpackage

// File: rtl/core/frx_in_stage.sv
// Input register of the frame receiver: captures one byte per beat.
// Depends on frx_pkg; advanced by the decode stage in frx_decode.
module frx_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  input  logic             adv,
  output frx_pkg::frx_beat_t beat
);
  import frx_pkg::*;

  logic       vld_r;
  logic [7:0] byte_r;
  logic       load;

  // take a new beat when empty or when the held beat moves on this cycle
  assign load     = !vld_r || adv;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign beat.vld     = vld_r;
  assign beat.rx_byte = byte_r;

endmodule

// File: rtl/core/frx_decode.sv
// Frame state, per-byte labeling and the result register.
// Depends on frx_pkg; fed by frx_in_stage.
module frx_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  frx_pkg::frx_beat_t beat,
  input  logic [7:0]         max_command,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output frx_pkg::frx_result_t res
);
  import frx_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRC  = 3'd5
  } phase_t;

  logic [7:0]  win_r [SYNC_LEN];
  logic [7:0]  win_nxt [SYNC_LEN];
  phase_t      phase_r, phase_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  dl_r, dl_nxt;
  logic [2:0]  cl_r, cl_nxt;
  logic        out_vld_r;
  frx_result_t res_r, res_nxt;
  logic        sync_hit;
  logic        framed;
  logic        hunt;
  logic [8:0]  off_inc;
  logic [7:0]  b;

  assign b   = beat.rx_byte;
  assign adv = beat.vld && (!out_vld_r || !out_stall);

  always_comb begin
    for (int i = 0; i < SYNC_LEN - 1; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[SYNC_LEN - 1] = b;
    sync_hit = 1'b1;
    for (int i = 0; i < SYNC_LEN; i++) begin
      if (win_nxt[i] != SYNC_BYTE) sync_hit = 1'b0;
    end

    phase_nxt              = phase_r;
    off_nxt                = off_r;
    dl_nxt                 = dl_r;
    cl_nxt                 = cl_r;
    framed                 = 1'b0;
    hunt                   = 1'b0;
    off_inc                = {1'b0, off_r} + 9'd1;
    res_nxt.byte_value     = b;
    res_nxt.frame_position = 8'd0;
    res_nxt.byte_kind      = KIND_IGNORED;
    res_nxt.frame_done     = 1'b0;
    res_nxt.error_code     = ERR_NONE;

    if (sync_hit) begin
      hunt              = 1'b1;
      res_nxt.byte_kind = KIND_PREAMBLE;
    end else begin
      res_nxt.frame_position = off_r;
      framed                 = 1'b1;
      case (phase_r)
        PH_CMD: begin
          res_nxt.byte_kind = KIND_COMMAND;
          if (b == 8'd0 || b >= max_command) begin
            res_nxt.error_code = ERR_INVALID;
            hunt               = 1'b1;
            framed             = 1'b0;
          end else begin
            phase_nxt = PH_ID;
          end
        end
        PH_ID: begin
          res_nxt.byte_kind = KIND_ID;
          phase_nxt         = PH_LEN;
        end
        PH_LEN: begin
          res_nxt.byte_kind = KIND_LENGTH;
          dl_nxt            = b;
          cl_nxt            = CRC_BYTES;
          phase_nxt         = (b != 8'd0) ? PH_DATA : PH_CRC;
        end
        PH_DATA: begin
          res_nxt.byte_kind = KIND_DATA;
          if (dl_r <= 8'd1) begin
            dl_nxt    = 8'd0;
            phase_nxt = PH_CRC;
          end else begin
            dl_nxt = dl_r - 8'd1;
          end
        end
        PH_CRC: begin
          res_nxt.byte_kind = KIND_CRC;
          if (cl_r <= 3'd1) begin
            cl_nxt             = 3'd0;
            res_nxt.frame_done = 1'b1;
            hunt               = 1'b1;
            framed             = 1'b0;
          end else begin
            cl_nxt = cl_r - 3'd1;
          end
        end
        default: begin
          phase_nxt              = PH_HUNT;
          res_nxt.frame_position = 8'd0;
          framed                 = 1'b0;
        end
      endcase

      if (framed) begin
        if (off_inc >= 9'(BUF_BYTES)) begin
          res_nxt.error_code = ERR_OVERFLOW;
          hunt               = 1'b1;
        end else begin
          off_nxt = off_inc[7:0];
        end
      end
    end

    // drop the window and offset; a preamble reopens at the command byte
    if (hunt) begin
      for (int i = 0; i < SYNC_LEN; i++) begin
        win_nxt[i] = 8'd0;
      end
      off_nxt   = 8'd0;
      phase_nxt = sync_hit ? PH_CMD : PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYNC_LEN; i++) begin
        win_r[i] <= 8'd0;
      end
      phase_r   <= PH_HUNT;
      off_r     <= 8'd0;
      dl_r      <= 8'd0;
      cl_r      <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        win_r     <= win_nxt;
        phase_r   <= phase_nxt;
        off_r     <= off_nxt;
        dl_r      <= dl_nxt;
        cl_r      <= cl_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign res       = res_r;

  a_done_is_crc : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.frame_done |-> res_r.byte_kind == KIND_CRC)
    else $error("frame_done on a non-CRC beat");

  a_invalid_is_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.error_code == ERR_INVALID |-> res_r.byte_kind == KIND_COMMAND)
    else $error("invalid-command error on a non-command beat");

  a_off_in_buf : assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, off_r} < 9'(BUF_BYTES))
    else $error("frame offset reached buffer size");

  a_done_hunts : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(adv) && $past(res_nxt.frame_done)
    |-> phase_r == PH_HUNT && off_r == 8'd0 && win_r[SYNC_LEN - 1] == 8'd0)
    else $error("state not cleared after last CRC byte");

  a_preamble_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(adv) && $past(sync_hit)
    |-> phase_r == PH_CMD && off_r == 8'd0)
    else $error("preamble did not open a frame");

endmodule

// File: rtl/core/preamble_length_frame_receiver.sv
// Top level of the preamble-synchronized, length-prefixed frame receiver.
// Depends on frx_pkg, frx_in_stage and frx_decode.
//
// Usage:
//   Input channel in_valid / in_stall / in_rx_byte carries one received byte
//   per beat. The output channel out_valid / out_stall carries one labeled
//   beat per input beat: the echoed byte, its offset in the frame, its kind
//   (ignored, preamble, command, id, length, data, crc), frame_done and an
//   error code (invalid command, buffer overflow abort).
//   Four 0x02 bytes in a row open a new frame at any time.
//   cfg_we / cfg_wdata write max_command; write it only while idle.
// Timing:
//   Throughput is one beat per cycle while out_stall is low. A beat is held
//   in the input register, then passes the decode logic into the result
//   register. Frame state updates in the same cycle the result register loads.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears the sync
//   window and returns to hunting; max_command resets to 255.
// Stall:
//   out_stall holds a valid result register; the input register takes one
//   more beat only if empty, then in_stall rises until the result moves on.
module preamble_length_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_frame_position,
  output logic [2:0] out_byte_kind,
  output logic       out_frame_done,
  output logic [1:0] out_error_code,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import frx_pkg::*;

  logic [7:0]  max_cmd_r;
  frx_beat_t   beat;
  frx_result_t res;
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cmd_r <= 8'hFF;
    end else if (cfg_we) begin
      max_cmd_r <= cfg_wdata;
    end
  end

  frx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .beat       (beat)
  );

  frx_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .max_command (max_cmd_r),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign out_byte_value     = res.byte_value;
  assign out_frame_position = res.frame_position;
  assign out_byte_kind      = res.byte_kind;
  assign out_frame_done     = res.frame_done;
  assign out_error_code     = res.error_code;

endmodule
